// ----- rtl/core/assert_macros.svh -----
// -----------------------------------------------------------------------------
// Assertion macros shared by the PID position drive RTL.
// Both expect a clock named clk and an active-low reset named rst_n in scope.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold on every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/ppmd_pkg.sv -----
// -----------------------------------------------------------------------------
// ppmd_pkg
// Widths, codes and shared types of the PID position motor drive.
// -----------------------------------------------------------------------------
package ppmd_pkg;

    localparam int ACC_W      = 128;  // exact PID sum accumulator
    localparam int MPL_W      = 64;   // serial multiplier operand
    localparam int CNT_W      = 7;    // bit counter of the serial MAC
    localparam int DIV_BITS   = 52;   // |diff * 1e6| < 2^52
    localparam int DIV_CNT_W  = 6;
    localparam int DERIV_W    = DIV_BITS + 1;
    localparam int ERR_W      = 32;
    localparam int GAIN_W     = 32;
    localparam int KI_W       = 48;
    localparam int INTEG_W    = 64;
    localparam int US_W       = 20;
    localparam int PD_SHIFT   = 24;   // P and D terms sit 2^24 above the I term
    localparam int DRIVE_LSB  = 40;   // drive = S >> 40
    localparam int DRIVE_W    = 8;
    localparam int DIR_W      = 2;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 48;
    localparam int OUT_DATA_W = 16;

    localparam logic [US_W-1:0]    US_PER_S  = 20'd1000000;
    localparam logic [GAIN_W-1:0]  KP_RESET  = 32'd131072;
    localparam logic [DRIVE_W-1:0] DRIVE_MAX = 8'd255;

    localparam logic [CFG_ADDR_W-1:0] REG_TARGET = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_KP     = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_KI     = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_KD     = 2'd3;

    localparam logic [DIR_W-1:0] DIR_STOP = 2'd0;
    localparam logic [DIR_W-1:0] DIR_FWD  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_REV  = 2'd2;

    typedef struct packed {
        logic             start;
        logic             clear;      // zero the accumulator on start
        logic             is_signed;  // top multiplier bit weighs negative
        logic [CNT_W-1:0] nbits;
    } mac_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_sts_t;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_PREP = 9'b000000010,
        S_MINT = 9'b000000100,
        S_MDIF = 9'b000001000,
        S_DIV  = 9'b000010000,
        S_MKP  = 9'b000100000,
        S_MKD  = 9'b001000000,
        S_MKI  = 9'b010000000,
        S_FIN  = 9'b100000000
    } state_t;

endpackage

// ----- rtl/core/ppmd_serial_mac.sv -----
// -----------------------------------------------------------------------------
// ppmd_serial_mac
// Bit-serial multiply-accumulate: one multiplier bit per cycle, LSB first.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module ppmd_serial_mac (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ppmd_pkg::mac_cmd_t            cmd,
    input  logic [ppmd_pkg::ACC_W-1:0]    mcand,
    input  logic [ppmd_pkg::MPL_W-1:0]    mplier,
    output logic [ppmd_pkg::ACC_W-1:0]    acc,
    output ppmd_pkg::unit_sts_t           sts
);
    import ppmd_pkg::*;

    logic [ACC_W-1:0] mc_reg, mc_next;
    logic [MPL_W-1:0] mp_reg, mp_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             sign_reg, sign_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic             last_bit;
    logic             sub;
    logic [ACC_W-1:0] step_sum;

    assign last_bit = (cnt_reg == CNT_W'(1));
    // two's-complement multiplier: its top bit is subtracted
    assign sub      = last_bit & sign_reg;
    assign step_sum = acc_reg + (mc_reg ^ {ACC_W{sub}}) + ACC_W'(sub);

    always_comb
    begin
        mc_next   = mc_reg;
        mp_next   = mp_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        sign_next = sign_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (cmd.start)
        begin
            mc_next   = mcand;
            mp_next   = mplier;
            cnt_next  = cmd.nbits;
            sign_next = cmd.is_signed;
            busy_next = 1'b1;
            if (cmd.clear)
            begin
                acc_next = '0;
            end
        end
        else if (busy_reg)
        begin
            if (mp_reg[0])
            begin
                acc_next = step_sum;
            end
            mc_next  = {mc_reg[ACC_W-2:0], 1'b0};
            mp_next  = {1'b0, mp_reg[MPL_W-1:1]};
            cnt_next = cnt_reg - CNT_W'(1);
            if (last_bit)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            sign_reg <= 1'b0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            sign_reg <= sign_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mc_reg  <= mc_next;
        mp_reg  <= mp_next;
        acc_reg <= acc_next;
    end

    assign acc      = acc_reg;
    assign sts.busy = busy_reg;
    assign sts.done = done_reg;

    `ASSERT_IMPLIES(a_mac_no_restart, cmd.start, !busy_reg, "MAC started while busy")
    `ASSERT_IMPLIES(a_mac_done_after_run, done_reg, $past(busy_reg) && !busy_reg,
                    "MAC done without a finished run")

endmodule

// ----- rtl/core/ppmd_serial_div.sv -----
// -----------------------------------------------------------------------------
// ppmd_serial_div
// Restoring unsigned divider, one quotient bit per cycle.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module ppmd_serial_div #(
    parameter int DIVISOR_W = 20
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [ppmd_pkg::DIV_BITS-1:0]   dividend,
    input  logic [DIVISOR_W-1:0]            divisor,
    output logic [ppmd_pkg::DIV_BITS-1:0]   quotient,
    output ppmd_pkg::unit_sts_t             sts
);
    import ppmd_pkg::*;

    // dividend shifts out the top while quotient bits shift in below
    logic [DIV_BITS-1:0]  dq_reg, dq_next;
    logic [DIVISOR_W-1:0] rem_reg, rem_next;
    logic [DIVISOR_W-1:0] dsr_reg, dsr_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    logic [DIVISOR_W:0]   trial;
    logic [DIVISOR_W:0]   trial_sub;
    logic                 fits;

    assign trial     = {rem_reg, dq_reg[DIV_BITS-1]};
    assign trial_sub = trial - {1'b0, dsr_reg};
    assign fits      = (trial >= {1'b0, dsr_reg});

    always_comb
    begin
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            dq_next   = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = DIV_CNT_W'(DIV_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? trial_sub[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            dq_next  = {dq_reg[DIV_BITS-2:0], fits};
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign quotient = dq_reg;
    assign sts.busy = busy_reg;
    assign sts.done = done_reg;

    `ASSERT_IMPLIES(a_div_no_restart, start, !busy_reg, "divider started while busy")

endmodule

// ----- rtl/core/pid_position_motor_drive.sv -----
// -----------------------------------------------------------------------------
// pid_position_motor_drive - fixed-point PID position controller, serial datapath
// Processing: each item runs through the bit-serial MAC (five products) and, unless
//   elapsed_us is zero (the divide is skipped), the 52-step divider; s_axis_tready
//   stays low until the result is registered, so one item is processed at a time.
// Reset: rst_n clears previous error and integral, loads the register defaults.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module pid_position_motor_drive #(
    parameter int TIME_WIDTH = 20
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // configuration write port
    input  logic                                   cfg_we,
    input  logic [ppmd_pkg::CFG_ADDR_W-1:0]        cfg_addr,
    input  logic [ppmd_pkg::CFG_DATA_W-1:0]        cfg_data,
    // input stream
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // tdata: [31:0] encoder_count, [32 +: TIME_WIDTH] elapsed_us, zero pad
    input  logic [((ppmd_pkg::ERR_W+TIME_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    // output stream
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // tdata: [1:0] direction, [9:2] drive_magnitude, [10] move_done, zero pad
    output logic [ppmd_pkg::OUT_DATA_W-1:0]        m_axis_tdata
);
    import ppmd_pkg::*;

    // configuration registers
    logic [ERR_W-1:0]  target_reg, target_next;
    logic [GAIN_W-1:0] kp_reg, kp_next;
    logic [KI_W-1:0]   ki_reg, ki_next;
    logic [GAIN_W-1:0] kd_reg, kd_next;

    // controller state
    state_t              state_reg, state_next;
    logic [ERR_W-1:0]    prev_reg, prev_next;
    logic [INTEG_W-1:0]  integ_reg, integ_next;
    logic                m_valid_reg, m_valid_next;

    // per-item working registers
    logic [ERR_W-1:0]      e_reg, e_next;
    logic [TIME_WIDTH-1:0] dt_reg, dt_next;
    logic [ERR_W:0]        diff_reg, diff_next;
    logic [DERIV_W-1:0]    deriv_reg, deriv_next;
    logic                  neg_reg, neg_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;

    // serial units
    mac_cmd_t            mac_cmd;
    logic [ACC_W-1:0]    mac_mcand;
    logic [MPL_W-1:0]    mac_mplier;
    logic [ACC_W-1:0]    mac_acc;
    unit_sts_t           mac_sts;
    logic                div_start;
    logic [DIV_BITS-1:0] div_q;
    unit_sts_t           div_sts;

    // input fields
    logic [ERR_W-1:0]      in_pos;
    logic [TIME_WIDTH-1:0] in_dt;

    // error, saturated to 32 bits
    logic [ERR_W:0]   err_wide;
    logic [ERR_W-1:0] err_sat;

    logic [ERR_W:0]   diff_wide;

    // integral update from e * dt
    logic [INTEG_W-1:0] prod64;
    logic [INTEG_W:0]   int_sum;
    logic [INTEG_W-1:0] int_sat;

    // divide operands and signed derivative
    logic [INTEG_W-1:0] prod_mag;
    logic [DERIV_W-1:0] deriv_val;

    // MAC operands of the three PID products
    logic [ACC_W-1:0] kp_mcand;
    logic [ACC_W-1:0] kd_mcand;
    logic [ACC_W-1:0] ki_mcand;

    // final drive
    logic [ACC_W-1:0]   s_mag;
    logic               drive_over;
    logic [DRIVE_W-1:0] drive_q;
    logic               drive_zero;
    logic [DIR_W-1:0]   drive_dir;

    assign in_pos = s_axis_tdata[ERR_W-1:0];
    assign in_dt  = s_axis_tdata[ERR_W +: TIME_WIDTH];

    assign err_wide = {target_reg[ERR_W-1], target_reg} - {in_pos[ERR_W-1], in_pos};
    always_comb
    begin
        if (err_wide[ERR_W] != err_wide[ERR_W-1])
        begin
            err_sat = err_wide[ERR_W] ? {1'b1, {(ERR_W-1){1'b0}}}
                                      : {1'b0, {(ERR_W-1){1'b1}}};
        end
        else
        begin
            err_sat = err_wide[ERR_W-1:0];
        end
    end

    // difference of two saturated errors always fits 33 bits
    assign diff_wide = {e_reg[ERR_W-1], e_reg} - {prev_reg[ERR_W-1], prev_reg};

    assign prod64  = mac_acc[INTEG_W-1:0];
    assign int_sum = {integ_reg[INTEG_W-1], integ_reg} + {prod64[INTEG_W-1], prod64};
    always_comb
    begin
        if (int_sum[INTEG_W] != int_sum[INTEG_W-1])
        begin
            int_sat = int_sum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                       : {1'b0, {(INTEG_W-1){1'b1}}};
        end
        else
        begin
            int_sat = int_sum[INTEG_W-1:0];
        end
    end

    // divide magnitudes, quotient sign follows the error difference
    assign prod_mag  = prod64[INTEG_W-1] ? (INTEG_W'(0) - prod64) : prod64;
    assign deriv_val = neg_reg ? (DERIV_W'(0) - {1'b0, div_q}) : {1'b0, div_q};

    // P and D terms carry the 2^24 weight in the multiplicand
    assign kp_mcand = {{(ACC_W-GAIN_W-PD_SHIFT){kp_reg[GAIN_W-1]}}, kp_reg,
                       {PD_SHIFT{1'b0}}};
    assign kd_mcand = {{(ACC_W-DERIV_W-PD_SHIFT){deriv_reg[DERIV_W-1]}}, deriv_reg,
                       {PD_SHIFT{1'b0}}};
    assign ki_mcand = {{(ACC_W-INTEG_W){integ_reg[INTEG_W-1]}}, integ_reg};

    // drive = trunc(S / 2^40) clamped: work on |S| so truncation goes toward zero
    assign s_mag      = mac_acc[ACC_W-1] ? (ACC_W'(0) - mac_acc) : mac_acc;
    assign drive_over = |s_mag[ACC_W-1:DRIVE_LSB+DRIVE_W];
    assign drive_q    = drive_over ? DRIVE_MAX : s_mag[DRIVE_LSB +: DRIVE_W];
    assign drive_zero = (drive_q == '0);
    assign drive_dir  = drive_zero ? DIR_STOP : (mac_acc[ACC_W-1] ? DIR_REV : DIR_FWD);

    always_comb
    begin
        target_next   = target_reg;
        kp_next       = kp_reg;
        ki_next       = ki_reg;
        kd_next       = kd_reg;
        state_next    = state_reg;
        prev_next     = prev_reg;
        integ_next    = integ_reg;
        m_valid_next  = m_valid_reg;
        e_next        = e_reg;
        dt_next       = dt_reg;
        diff_next     = diff_reg;
        deriv_next    = deriv_reg;
        neg_next      = neg_reg;
        out_data_next = out_data_reg;
        mac_cmd       = '0;
        mac_mcand     = '0;
        mac_mplier    = '0;
        div_start     = 1'b0;

        if (cfg_we)
        begin
            case (cfg_addr)
                REG_TARGET: target_next = cfg_data[ERR_W-1:0];
                REG_KP:     kp_next     = cfg_data[GAIN_W-1:0];
                REG_KI:     ki_next     = cfg_data[KI_W-1:0];
                REG_KD:     kd_next     = cfg_data[GAIN_W-1:0];
                default:    ;
            endcase
        end

        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    e_next     = err_sat;
                    dt_next    = in_dt;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                // e * dt for the integral
                diff_next         = diff_wide;
                prev_next         = e_reg;
                mac_cmd.start     = 1'b1;
                mac_cmd.clear     = 1'b1;
                mac_cmd.is_signed = 1'b0;
                mac_cmd.nbits     = CNT_W'(TIME_WIDTH);
                mac_mcand         = {{(ACC_W-ERR_W){e_reg[ERR_W-1]}}, e_reg};
                mac_mplier        = {{(MPL_W-TIME_WIDTH){1'b0}}, dt_reg};
                state_next        = S_MINT;
            end
            S_MINT:
            begin
                if (mac_sts.done)
                begin
                    // dt of zero gives a zero product: integral unchanged
                    integ_next        = int_sat;
                    mac_cmd.start     = 1'b1;
                    mac_cmd.clear     = 1'b1;
                    mac_cmd.is_signed = 1'b0;
                    mac_cmd.nbits     = CNT_W'(US_W);
                    mac_mcand         = {{(ACC_W-ERR_W-1){diff_reg[ERR_W]}}, diff_reg};
                    mac_mplier        = {{(MPL_W-US_W){1'b0}}, US_PER_S};
                    state_next        = S_MDIF;
                end
            end
            S_MDIF:
            begin
                if (mac_sts.done)
                begin
                    if (dt_reg == '0)
                    begin
                        // no time elapsed: derivative taken as zero
                        deriv_next        = '0;
                        mac_cmd.start     = 1'b1;
                        mac_cmd.clear     = 1'b1;
                        mac_cmd.is_signed = 1'b1;
                        mac_cmd.nbits     = CNT_W'(ERR_W);
                        mac_mcand         = kp_mcand;
                        mac_mplier        = {{(MPL_W-ERR_W){1'b0}}, e_reg};
                        state_next        = S_MKP;
                    end
                    else
                    begin
                        neg_next   = prod64[INTEG_W-1];
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                if (div_sts.done)
                begin
                    deriv_next        = deriv_val;
                    mac_cmd.start     = 1'b1;
                    mac_cmd.clear     = 1'b1;
                    mac_cmd.is_signed = 1'b1;
                    mac_cmd.nbits     = CNT_W'(ERR_W);
                    mac_mcand         = kp_mcand;
                    mac_mplier        = {{(MPL_W-ERR_W){1'b0}}, e_reg};
                    state_next        = S_MKP;
                end
            end
            S_MKP:
            begin
                if (mac_sts.done)
                begin
                    mac_cmd.start     = 1'b1;
                    mac_cmd.clear     = 1'b0;
                    mac_cmd.is_signed = 1'b1;
                    mac_cmd.nbits     = CNT_W'(GAIN_W);
                    mac_mcand         = kd_mcand;
                    mac_mplier        = {{(MPL_W-GAIN_W){1'b0}}, kd_reg};
                    state_next        = S_MKD;
                end
            end
            S_MKD:
            begin
                if (mac_sts.done)
                begin
                    mac_cmd.start     = 1'b1;
                    mac_cmd.clear     = 1'b0;
                    mac_cmd.is_signed = 1'b1;
                    mac_cmd.nbits     = CNT_W'(KI_W);
                    mac_mcand         = ki_mcand;
                    mac_mplier        = {{(MPL_W-KI_W){1'b0}}, ki_reg};
                    state_next        = S_MKI;
                end
            end
            S_MKI:
            begin
                if (mac_sts.done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                // wait for the output register to free up
                if (!m_valid_reg || m_axis_tready)
                begin
                    out_data_next = {{(OUT_DATA_W-DIR_W-DRIVE_W-1){1'b0}},
                                     drive_zero, drive_q, drive_dir};
                    m_valid_next  = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg  <= '0;
            kp_reg      <= KP_RESET;
            ki_reg      <= '0;
            kd_reg      <= '0;
            state_reg   <= S_IDLE;
            prev_reg    <= '0;
            integ_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            target_reg  <= target_next;
            kp_reg      <= kp_next;
            ki_reg      <= ki_next;
            kd_reg      <= kd_next;
            state_reg   <= state_next;
            prev_reg    <= prev_next;
            integ_reg   <= integ_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        e_reg        <= e_next;
        dt_reg       <= dt_next;
        diff_reg     <= diff_next;
        deriv_reg    <= deriv_next;
        neg_reg      <= neg_next;
        out_data_reg <= out_data_next;
    end

    ppmd_serial_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (mac_cmd),
        .mcand  (mac_mcand),
        .mplier (mac_mplier),
        .acc    (mac_acc),
        .sts    (mac_sts)
    );

    ppmd_serial_div #(
        .DIVISOR_W (TIME_WIDTH)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_mag[DIV_BITS-1:0]),
        .divisor  (dt_reg),
        .quotient (div_q),
        .sts      (div_sts)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // the MAC and the divider take turns, never overlap
    `ASSERT_IMPLIES(a_units_exclusive, mac_sts.busy, !div_sts.busy,
                    "MAC and divider busy together")
    // a new item only enters with both serial units quiet
    `ASSERT_IMPLIES(a_accept_units_idle, s_axis_tvalid && s_axis_tready,
                    !mac_sts.busy && !div_sts.busy, "input taken while units busy")

endmodule
